// File: rtl/core/efr_pkg.sv
`default_nettype none

package efr_pkg;

  // Ring geometry. The pointer width follows the ring depth.
  localparam int unsigned BUFFER_SIZE = 64;
  localparam int unsigned PTR_W = $clog2(BUFFER_SIZE);

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t PTR_MAX = ptr_t'(BUFFER_SIZE - 1);

  // Result kinds on the output channel.
  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_MSG  = 2'd1,
    KIND_SIZE = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_START  = 2'd0,
    CFG_END    = 2'd1,
    CFG_ESCAPE = 2'd2
  } cfg_idx_t;

  // Acknowledge frame contents.
  localparam logic [7:0] ACK_TYPE  = 8'h02;
  localparam logic [7:0] ACK_START = 8'h01;
  localparam logic [7:0] ACK_END   = 8'h04;
  localparam logic [7:0] ACK_ESC   = 8'h00;
  localparam logic [7:0] ACK_DATA  = 8'h02;

  // Control codes of the line.
  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
  } codes_t;

  // One result item.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } res_t;

  // Next ring position, wrapping at the ring depth.
  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == PTR_MAX) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  // Distance from b forward to e around the ring.
  function automatic ptr_t ptr_dist(input ptr_t e, input ptr_t b);
    logic [PTR_W:0] d;
    d = {1'b0, e} - {1'b0, b};
    if (e < b) begin
      d = d + (PTR_W+1)'(BUFFER_SIZE);
    end
    return ptr_t'(d);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/escaped_frame_receiver.sv
`default_nettype none

// Byte-stuffed frame receiver. Each input transaction is either a received
// line byte (in_tuser low) or a fetch of the pending message (in_tuser high,
// caller's buffer room in in_tdata[15:8]). Frame bytes are stored in a
// 64-entry ring memory; a closed frame becomes the pending message if none
// is pending yet. Start, end, escape and stored-data bytes answer with a
// four-byte acknowledge frame in which control bytes are escaped, while a
// dropped byte is accepted with no result. A fetch is accepted, then each
// message byte passes through the ring's registered read and then the
// output load, and a size result closes it.
// One transaction is in work at a time; results leave through an output
// register and are held while out_tready is low. The three control codes
// may be written only while the block is idle.
module escaped_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] rx_byte, [15:8] room
  input  wire logic        in_tlast,   // packet_last
  input  wire logic        in_tuser,   // [0] func
  // Result stream
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [7:0]  out_tdata,  // [7:0] value
  output      logic        out_tlast,  // last
  output      logic [1:0]  out_tuser,  // [1:0] kind
  // Configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACK  = 5'b00010,
    S_RD   = 5'b00100,
    S_MSG  = 5'b01000,
    S_SIZE = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  efr_pkg::codes_t codes_r;
  efr_pkg::ptr_t   head_r, head_nxt;
  efr_pkg::ptr_t   msg_begin_r, msg_begin_nxt;
  efr_pkg::ptr_t   msg_end_r, msg_end_nxt;
  logic            open_r, open_nxt;
  logic            esc_r, esc_nxt;
  logic            ready_r, ready_nxt;
  efr_pkg::ptr_t   rd_ptr_r, rd_ptr_nxt;
  efr_pkg::ptr_t   cnt_r, cnt_nxt;
  efr_pkg::ptr_t   size_r, size_nxt;

  logic            out_valid_r;
  efr_pkg::res_t   out_res_r;

  logic            accept;
  logic            slot_free;
  logic            load;
  efr_pkg::res_t   load_res;

  logic            ack_start;
  logic [7:0]      ack_code;
  logic            ack_valid;
  efr_pkg::res_t   ack_res;
  logic            ack_take;

  logic            ram_we;
  efr_pkg::ptr_t   ram_waddr;
  logic [7:0]      ram_wdata;
  logic            ram_re;
  logic [7:0]      ram_q;

  logic [7:0]      rx_byte;
  logic [7:0]      room;
  efr_pkg::ptr_t   next_head;
  efr_pkg::ptr_t   pend_size;

  assign rx_byte   = in_tdata[7:0];
  assign room      = in_tdata[15:8];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign next_head = efr_pkg::ptr_inc(head_r);
  assign pend_size = efr_pkg::ptr_dist(msg_end_r, msg_begin_r);
  assign ack_take  = (state_r == S_ACK) && slot_free;

  efr_ring_ram u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_q)
  );

  efr_ack_gen u_ack (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ack_start),
    .code      (ack_code),
    .codes     (codes_r),
    .take      (ack_take),
    .res_valid (ack_valid),
    .res       (ack_res)
  );

  // Transaction decode and result sequencing.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    msg_begin_nxt = msg_begin_r;
    msg_end_nxt   = msg_end_r;
    open_nxt      = open_r;
    esc_nxt       = esc_r;
    ready_nxt     = ready_r;
    rd_ptr_nxt    = rd_ptr_r;
    cnt_nxt       = cnt_r;
    size_nxt      = size_r;
    ack_start     = 1'b0;
    ack_code      = efr_pkg::ACK_DATA;
    ram_we        = 1'b0;
    ram_waddr     = next_head;
    ram_wdata     = rx_byte;
    ram_re        = 1'b0;
    load          = 1'b0;
    load_res      = ack_res;

    unique case (state_r)
      S_IDLE: begin
        if (accept && !in_tuser) begin
          // Received byte: start code wins over end, end over escape.
          if (rx_byte == codes_r.start_code) begin
            head_nxt  = msg_end_r;
            open_nxt  = 1'b1;
            esc_nxt   = 1'b0;
            ack_start = 1'b1;
            ack_code  = efr_pkg::ACK_START;
            state_nxt = S_ACK;
          end else if (!open_r) begin
            state_nxt = S_IDLE;
          end else if (rx_byte == codes_r.end_code) begin
            open_nxt = 1'b0;
            if (!ready_r) begin
              msg_begin_nxt = msg_end_r;
              msg_end_nxt   = head_r;
              ready_nxt     = 1'b1;
            end
            ack_start = 1'b1;
            ack_code  = efr_pkg::ACK_END;
            state_nxt = S_ACK;
          end else if (rx_byte == codes_r.escape_code) begin
            esc_nxt   = 1'b1;
            ack_start = 1'b1;
            ack_code  = efr_pkg::ACK_ESC;
            state_nxt = S_ACK;
          end else if (next_head == msg_begin_r) begin
            // Ring full: abort the frame silently.
            open_nxt = 1'b0;
          end else begin
            head_nxt  = next_head;
            ram_we    = 1'b1;
            ram_wdata = esc_r ? (rx_byte - 8'd1) : rx_byte;
            esc_nxt   = 1'b0;
            ack_start = 1'b1;
            ack_code  = efr_pkg::ACK_DATA;
            state_nxt = S_ACK;
          end
        end else if (accept) begin
          // Fetch: the pending message is released in every case.
          if (!ready_r) begin
            size_nxt  = '0;
            state_nxt = S_SIZE;
          end else begin
            ready_nxt = 1'b0;
            size_nxt  = pend_size;
            if ((8'(pend_size) <= room) && (pend_size != '0)) begin
              rd_ptr_nxt = efr_pkg::ptr_inc(msg_begin_r);
              cnt_nxt    = pend_size;
              state_nxt  = S_RD;
            end else begin
              state_nxt = S_SIZE;
            end
          end
        end
      end

      S_ACK: begin
        if (ack_valid && slot_free) begin
          load     = 1'b1;
          load_res = ack_res;
          if (ack_res.last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_RD: begin
        ram_re     = 1'b1;
        rd_ptr_nxt = efr_pkg::ptr_inc(rd_ptr_r);
        state_nxt  = S_MSG;
      end

      S_MSG: begin
        if (slot_free) begin
          load           = 1'b1;
          load_res.kind  = efr_pkg::KIND_MSG;
          load_res.value = ram_q;
          load_res.last  = 1'b0;
          cnt_nxt        = cnt_r - efr_pkg::ptr_t'(1);
          state_nxt      = (cnt_r == efr_pkg::ptr_t'(1)) ? S_SIZE : S_RD;
        end
      end

      S_SIZE: begin
        if (slot_free) begin
          load           = 1'b1;
          load_res.kind  = efr_pkg::KIND_SIZE;
          load_res.value = 8'(size_r);
          load_res.last  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      msg_begin_r <= '0;
      msg_end_r   <= '0;
      open_r      <= 1'b0;
      esc_r       <= 1'b0;
      ready_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      msg_begin_r <= msg_begin_nxt;
      msg_end_r   <= msg_end_nxt;
      open_r      <= open_nxt;
      esc_r       <= esc_nxt;
      ready_r     <= ready_nxt;
    end
  end

  // Fetch counters.
  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    cnt_r    <= cnt_nxt;
    size_r   <= size_nxt;
  end

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.start_code  <= 8'd16;
      codes_r.end_code    <= 8'd32;
      codes_r.escape_code <= 8'd48;
    end else if (cfg_we) begin
      unique case (cfg_index)
        efr_pkg::CFG_START:  codes_r.start_code  <= cfg_data;
        efr_pkg::CFG_END:    codes_r.end_code    <= cfg_data;
        efr_pkg::CFG_ESCAPE: codes_r.escape_code <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= load_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.value;
  assign out_tlast  = out_res_r.last;
  assign out_tuser  = out_res_r.kind;

  // The packet marker carries no meaning for this block.
  logic unused_tlast;
  assign unused_tlast = in_tlast;

endmodule

`default_nettype wire

// File: rtl/core/efr_ring_ram.sv
`default_nettype none

module efr_ring_ram (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire efr_pkg::ptr_t     wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic              rd_en,
  input  wire efr_pkg::ptr_t     rd_addr,
  output      logic [7:0]        rd_data
);

  logic [7:0] mem [efr_pkg::BUFFER_SIZE];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/efr_ack_gen.sv
`default_nettype none

module efr_ack_gen (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [7:0]      code,
  input  wire efr_pkg::codes_t codes,
  input  wire logic            take,
  output      logic            res_valid,
  output      efr_pkg::res_t   res
);

  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       phase_r, phase_nxt;
  logic [7:0] code_r, code_nxt;

  logic [7:0] frame_byte;
  logic       is_ctrl;
  logic       byte_done;

  // Select the byte of the acknowledge frame now being sent.
  always_comb begin
    unique case (idx_r)
      2'd0:    frame_byte = codes.start_code;
      2'd1:    frame_byte = efr_pkg::ACK_TYPE;
      2'd2:    frame_byte = code_r;
      2'd3:    frame_byte = codes.end_code;
      default: frame_byte = codes.end_code;
    endcase
  end

  // A control byte goes out as escape followed by the byte plus one.
  always_comb begin
    is_ctrl   = (frame_byte == codes.start_code) || (frame_byte == codes.end_code) ||
                (frame_byte == codes.escape_code);
    byte_done = phase_r || !is_ctrl;
    res.kind  = efr_pkg::KIND_ACK;
    res.last  = byte_done && (idx_r == 2'd3);
    if (phase_r) begin
      res.value = frame_byte + 8'd1;
    end else if (is_ctrl) begin
      res.value = codes.escape_code;
    end else begin
      res.value = frame_byte;
    end
    res_valid = busy_r;
  end

  // Sequencer over the four frame bytes and the escape phase.
  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    code_nxt  = code_r;
    if (start) begin
      busy_nxt  = 1'b1;
      idx_nxt   = 2'd0;
      phase_nxt = 1'b0;
      code_nxt  = code;
    end else if (busy_r && take) begin
      if (byte_done) begin
        phase_nxt = 1'b0;
        idx_nxt   = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          busy_nxt = 1'b0;
        end
      end else begin
        phase_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= 2'd0;
      phase_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

endmodule

`default_nettype wire
